### rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types, token codes and character classes of the source tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int POSITION_BITS     = 24;
    localparam int MAX_NUMBER_DIGITS = 10;
    localparam int MAX_WORD_LENGTH   = 255;

    typedef enum logic [2:0] {
        M_IDLE   = 3'd0,
        M_OPER   = 3'd1,
        M_NUMBER = 3'd2,
        M_WORD   = 3'd3,
        M_STRING = 3'd4,
        M_ESCAPE = 3'd5
    } t_mode;

    localparam logic [5:0] K_EOF     = 6'd0;
    localparam logic [5:0] K_INT     = 6'd1;
    localparam logic [5:0] K_STRING  = 6'd2;
    localparam logic [5:0] K_SBYTE   = 6'd3;
    localparam logic [5:0] K_IDENT   = 6'd4;
    localparam logic [5:0] K_TYPE    = 6'd5;
    localparam logic [5:0] K_ERROR   = 6'd6;
    localparam logic [5:0] K_UNKNOWN = 6'd7;
    localparam logic [5:0] K_AND     = 6'd24;
    localparam logic [5:0] K_OR      = 6'd25;

    typedef struct packed {
        logic [5:0]  kind;
        logic [30:0] value;
        logic [23:0] start;
        logic [15:0] length;
    } t_token;

    function automatic logic [5:0] held_base(input logic [7:0] c);
        case (c)
            8'h2B:   return 6'd8;
            8'h2D:   return 6'd10;
            8'h2A:   return 6'd12;
            8'h2F:   return 6'd14;
            8'h3D:   return 6'd16;
            8'h21:   return 6'd18;
            8'h3C:   return 6'd20;
            8'h3E:   return 6'd22;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            8'h28:   return 6'd26;
            8'h29:   return 6'd27;
            8'h3B:   return 6'd28;
            8'h3A:   return 6'd29;
            8'h7B:   return 6'd30;
            8'h7D:   return 6'd31;
            8'h5B:   return 6'd32;
            8'h5D:   return 6'd33;
            8'h2C:   return 6'd34;
            8'h25:   return 6'd35;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_word_letter(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]}) || (c == 8'h5F);
    endfunction

endpackage

### rtl/sct_keyword.sv
// ----------------------------------------------------------------------------
// sct_keyword
// Keyword and type-name match of a finished word, all compares in parallel.
// ----------------------------------------------------------------------------
module sct_keyword import sct_pkg::*; (
    input  logic [47:0] i_window,
    input  logic [15:0] i_length,
    output logic [5:0]  o_kind,
    output logic [1:0]  o_code
);
    always_comb begin
        o_kind = K_IDENT;
        o_code = 2'd0;
        case (i_length)
            16'd2: begin
                if (i_window == 48'h6966) o_kind = 6'd36;
                else if (i_window == 48'h666E) o_kind = 6'd37;
            end
            16'd3: begin
                if (i_window == 48'h766172) o_kind = 6'd38;
                else if (i_window == 48'h696E74) o_kind = K_TYPE;
            end
            16'd4: begin
                if (i_window == 48'h74727565) o_kind = 6'd39;
                else if (i_window == 48'h626F6F6C) begin
                    o_kind = K_TYPE;
                    o_code = 2'd1;
                end else if (i_window == 48'h656C7365) o_kind = 6'd40;
            end
            16'd5: begin
                if (i_window == 48'h66616C7365) o_kind = 6'd41;
                else if (i_window == 48'h7768696C65) o_kind = 6'd42;
            end
            16'd6: begin
                if (i_window == 48'h72657475726E) o_kind = 6'd43;
                else if (i_window == 48'h737472696E67) begin
                    o_kind = K_TYPE;
                    o_code = 2'd2;
                end
            end
            default: o_kind = K_IDENT;
        endcase
    end
endmodule

### rtl/source_char_tokenizer.sv
// ----------------------------------------------------------------------------
// source_char_tokenizer
// Streaming lexer: one source byte in, up to two tokens out.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries one source byte per transfer; a zero
// byte ends the source, flushes any pending token, emits EOF and restarts the
// offset count. Output channel o_valid/i_ready carries one token per transfer
// with kind, value, start offset, length and run_last, which marks the last
// token caused by a byte.
// A byte is lexed in the cycle it is accepted, against the scanner state, and
// its tokens land in a two-entry result register the next cycle. A byte is
// accepted in any cycle in which the result register is empty or its last
// token is being sent; a byte that makes two tokens holds the input while
// its first token leaves. Throughput is one byte per cycle otherwise, while
// the receiver is ready, set by the single-pass lexing logic and the
// one-token-per-cycle output port.
// Synchronous active-low reset returns the scanner to idle, offset zero, and
// empties the result register. When the receiver stalls, the token holds and
// input stops while any token waits.
// ----------------------------------------------------------------------------
module source_char_tokenizer import sct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_source_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_token_kind,
    output logic [30:0] o_token_value,
    output logic [23:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic        o_run_last
);
    t_mode       r_mode, n_mode;
    logic [7:0]  r_held, n_held;
    logic [33:0] r_acc, n_acc;
    logic [3:0]  r_digits, n_digits;
    logic [15:0] r_wlen, n_wlen;
    logic [47:0] r_window, n_window;
    logic [23:0] r_pos, n_pos;
    logic [23:0] r_start, n_start;

    t_token      r_tok0, r_tok1, n_tok0, n_tok1;
    logic [1:0]  r_cnt, n_cnt;
    logic        r_sel;

    logic [5:0]  w_kw_kind;
    logic [1:0]  w_kw_code;
    logic        w_take;
    logic [7:0]  c;
    logic        again;
    t_token      e0, e1, ef;
    logic [1:0]  ne;
    logic [5:0]  k;

    sct_keyword u_kw (
        .i_window(r_window),
        .i_length(r_wlen),
        .o_kind  (w_kw_kind),
        .o_code  (w_kw_code)
    );

    assign o_valid = (r_cnt != 2'd0);
    assign o_ready = (r_cnt == 2'd0) || (i_ready && r_cnt == 2'd1);
    assign w_take  = i_valid && o_ready;
    assign c       = i_source_byte;

    assign o_token_kind   = r_sel ? r_tok1.kind   : r_tok0.kind;
    assign o_token_value  = r_sel ? r_tok1.value  : r_tok0.value;
    assign o_start_offset = r_sel ? r_tok1.start  : r_tok0.start;
    assign o_token_length = r_sel ? r_tok1.length : r_tok0.length;
    assign o_run_last     = (r_cnt == 2'd1);

    always_comb begin
        n_mode   = r_mode;
        n_held   = r_held;
        n_acc    = r_acc;
        n_digits = r_digits;
        n_wlen   = r_wlen;
        n_window = r_window;
        n_start  = r_start;
        again    = 1'b0;
        e0       = '0;
        e1       = '0;
        ef       = '0;
        ne       = 2'd0;
        k        = 6'd0;
        case (r_mode)
            M_OPER: begin
                n_mode = M_IDLE;
                if (r_held == 8'h26 || r_held == 8'h7C) begin
                    if (c == r_held) begin
                        e0 = '{(r_held == 8'h26) ? K_AND : K_OR, 31'd0, r_start, 16'd2};
                    end else begin
                        e0 = '{K_ERROR, 31'd0, r_start, 16'd1};
                        again = 1'b1;
                    end
                end else if (c == 8'h3D) begin
                    e0 = '{held_base(r_held) + 6'd1, 31'd0, r_start, 16'd2};
                end else begin
                    e0 = '{held_base(r_held), 31'd0, r_start, 16'd1};
                    again = 1'b1;
                end
                ne = 2'd1;
            end
            M_NUMBER: begin
                if (is_numeral(c) && r_digits < 4'(MAX_NUMBER_DIGITS)) begin
                    n_acc    = 34'((r_acc << 3) + (r_acc << 1) + {30'd0, c[3:0]});
                    n_digits = r_digits + 4'd1;
                end else begin
                    if (r_acc > 34'd2147483647)
                        e0 = '{K_ERROR, 31'd0, r_start, {12'd0, r_digits}};
                    else
                        e0 = '{K_INT, r_acc[30:0], r_start, {12'd0, r_digits}};
                    ne = 2'd1;
                    again = 1'b1;
                end
            end
            M_WORD: begin
                if (is_word_letter(c)) begin
                    if (r_wlen >= 16'(MAX_WORD_LENGTH)) begin
                        e0 = '{K_ERROR, 31'd0, r_start,
                               (r_wlen == 16'hFFFF) ? 16'hFFFF : r_wlen + 16'd1};
                        ne = 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        n_wlen   = r_wlen + 16'd1;
                        n_window = {r_window[39:0], c};
                    end
                end else begin
                    e0 = '{w_kw_kind, {29'd0, w_kw_code}, r_start, r_wlen};
                    ne = 2'd1;
                    again = 1'b1;
                end
            end
            M_STRING: begin
                if (c == 8'h22) begin
                    e0 = '{K_STRING, 31'd0, r_start, r_wlen};
                    ne = 2'd1;
                    n_mode = M_IDLE;
                end else if (c == 8'h00) begin
                    e0 = '{K_ERROR, 31'd0, r_start, r_wlen};
                    ne = 2'd1;
                    again = 1'b1;
                end else if (c == 8'h5C) begin
                    n_mode = M_ESCAPE;
                end else begin
                    e0 = '{K_SBYTE, {23'd0, c}, r_pos, 16'd1};
                    ne = 2'd1;
                    if (r_wlen != 16'hFFFF) n_wlen = r_wlen + 16'd1;
                end
            end
            M_ESCAPE: begin
                if (c == 8'h00) begin
                    e0 = '{K_ERROR, 31'd0, r_start, r_wlen};
                    ne = 2'd1;
                    again = 1'b1;
                end else begin
                    case (c)
                        8'h6E:   e0.value = 31'd10;
                        8'h74:   e0.value = 31'd9;
                        8'h72:   e0.value = 31'd13;
                        8'h30:   e0.value = 31'd0;
                        default: e0.value = {23'd0, c};
                    endcase
                    e0.kind   = K_SBYTE;
                    e0.start  = r_pos - 24'd1;
                    e0.length = 16'd2;
                    ne = 2'd1;
                    if (r_wlen != 16'hFFFF) n_wlen = r_wlen + 16'd1;
                    n_mode = M_STRING;
                end
            end
            default: again = 1'b1;
        endcase

        if (again) begin
            n_mode = M_IDLE;
            k = single_kind(c);
            if (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D) begin
                n_mode = M_IDLE;
            end else if (c == 8'h00) begin
                ef = '{K_EOF, 31'd0, r_pos, 16'd0};
            end else if (held_base(c) != 6'd0 || c == 8'h26 || c == 8'h7C) begin
                n_mode  = M_OPER;
                n_held  = c;
                n_start = r_pos;
            end else if (k != 6'd0) begin
                ef = '{k, 31'd0, r_pos, 16'd1};
            end else if (is_numeral(c)) begin
                n_mode   = M_NUMBER;
                n_acc    = {30'd0, c[3:0]};
                n_digits = 4'd1;
                n_start  = r_pos;
            end else if (is_word_letter(c)) begin
                n_mode   = M_WORD;
                n_wlen   = 16'd1;
                n_window = {40'd0, c};
                n_start  = r_pos;
            end else if (c == 8'h22) begin
                n_mode  = M_STRING;
                n_wlen  = 16'd0;
                n_start = r_pos + 24'd1;
            end else begin
                ef = '{K_UNKNOWN, 31'd0, r_pos, 16'd1};
            end
            if (ef.kind != 6'd0 || c == 8'h00 || ef.length != 16'd0) begin
                if (ne == 2'd0) e0 = ef;
                else            e1 = ef;
                ne = ne + 2'd1;
            end
        end
        n_pos = (c == 8'h00) ? 24'd0 : r_pos + 24'd1;
    end

    always_comb begin
        n_tok0 = r_tok0;
        n_tok1 = r_tok1;
        n_cnt  = r_cnt;
        if (o_valid && i_ready) n_cnt = r_cnt - 2'd1;
        if (w_take) begin
            n_tok0 = e0;
            n_tok1 = e1;
            n_cnt  = ne;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_held   <= '0;
            r_acc    <= '0;
            r_digits <= '0;
            r_wlen   <= '0;
            r_window <= '0;
            r_pos    <= '0;
            r_start  <= '0;
            r_cnt    <= '0;
            r_sel    <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_take) begin
                r_mode   <= n_mode;
                r_held   <= n_held;
                r_acc    <= n_acc;
                r_digits <= n_digits;
                r_wlen   <= n_wlen;
                r_window <= n_window;
                r_pos    <= n_pos;
                r_start  <= n_start;
                r_sel    <= 1'b0;
            end else if (o_valid && i_ready) begin
                r_sel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok0 <= n_tok0;
        r_tok1 <= n_tok1;
    end
endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams source bytes into source_char_tokenizer and checks every token
// against a cycle-free lexer predictor. A short directed table (offsets,
// value overflow, lone pair operator, escapes, unterminated string,
// keywords) is followed by random program-like text with noise.
// ----------------------------------------------------------------------------
module testbench;
    import sct_pkg::*;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        t_token     tok;
    } t_row;

    typedef struct {
        t_token tok;
        bit     last;
    } t_expect;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_source_byte = 8'h00;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [5:0]  o_token_kind;
    logic [30:0] o_token_value;
    logic [23:0] o_start_offset;
    logic [15:0] o_token_length;
    logic        o_run_last;

    source_char_tokenizer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_source_byte(i_source_byte),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_token_kind(o_token_kind), .o_token_value(o_token_value),
        .o_start_offset(o_start_offset), .o_token_length(o_token_length),
        .o_run_last(o_run_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    localparam int N_DIR = 30;
    t_row dir_table [N_DIR] = '{
        '{8'h00, 1'b1, '{K_EOF, 31'd0, 24'd0, 16'd0}},
        '{"%",   1'b1, '{6'd35, 31'd0, 24'd0, 16'd1}},
        '{"2", 1'b0, '0}, '{"1", 1'b0, '0}, '{"4", 1'b0, '0}, '{"7", 1'b0, '0},
        '{"4", 1'b0, '0}, '{"8", 1'b0, '0}, '{"3", 1'b0, '0}, '{"6", 1'b0, '0},
        '{"4", 1'b0, '0}, '{"8", 1'b0, '0},
        '{" ",   1'b1, '{K_ERROR, 31'd0, 24'd1, 16'd10}},
        '{"&", 1'b0, '0}, '{"x", 1'b0, '0}, '{"|", 1'b0, '0}, '{"|", 1'b0, '0},
        '{8'h22, 1'b0, '0}, '{8'h5C, 1'b0, '0}, '{"n", 1'b0, '0},
        '{8'hFF, 1'b1, '{K_SBYTE, 31'd255, 24'd19, 16'd1}},
        '{8'h00, 1'b0, '0},
        '{"<",   1'b0, '0},
        '{"=",   1'b1, '{6'd21, 31'd0, 24'd0, 16'd2}},
        '{"r", 1'b0, '0}, '{"e", 1'b0, '0}, '{"t", 1'b0, '0}, '{"u", 1'b0, '0},
        '{"r", 1'b0, '0}, '{"n", 1'b0, '0}
    };

    t_row        src_q [$];
    t_expect     token_q [$];
    t_expect     new_tokens [$];
    int          errors = 0;
    int          long_words = 0;
    bit          calm = 1'b0;
    int          in_gap = 0;
    int          out_gap = 0;
    t_row        cur_row;

    // lexer state
    t_mode       mode = M_IDLE;
    logic [7:0]  held_op = '0;
    logic [33:0] number_acc = '0;
    logic [3:0]  digits = '0;
    logic [15:0] word_len = '0;
    logic [47:0] kw_window = '0;
    logic [23:0] position = '0;
    logic [23:0] tok_start = '0;

    function automatic bit is_space(logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic logic [5:0] base_of(logic [7:0] c);
        case (c)
            "+": return 6'd8;
            "-": return 6'd10;
            "*": return 6'd12;
            "/": return 6'd14;
            "=": return 6'd16;
            "!": return 6'd18;
            "<": return 6'd20;
            ">": return 6'd22;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [5:0] punct_of(logic [7:0] c);
        case (c)
            "(": return 6'd26;
            ")": return 6'd27;
            ";": return 6'd28;
            ":": return 6'd29;
            "{": return 6'd30;
            "}": return 6'd31;
            "[": return 6'd32;
            "]": return 6'd33;
            ",": return 6'd34;
            "%": return 6'd35;
            default: return 6'd0;
        endcase
    endfunction

    function automatic bit digit_char(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit word_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    task automatic add_token(logic [5:0] kind, logic [30:0] value, logic [23:0] start,
                             logic [16:0] len);
        t_expect e;
        e.tok = '{kind, value, start, (len > 17'hFFFF) ? 16'hFFFF : len[15:0]};
        e.last = 1'b0;
        if (new_tokens.size() < 2) new_tokens.push_back(e);
    endtask

    task automatic flush_word();
        logic [5:0]  kind;
        logic [30:0] code;
        kind = K_IDENT;
        code = '0;
        if (word_len <= 6) begin
            case (kw_window)
                "if":     kind = 6'd36;
                "fn":     kind = 6'd37;
                "var":    kind = 6'd38;
                "int":    kind = K_TYPE;
                "true":   kind = 6'd39;
                "bool":   begin kind = K_TYPE; code = 31'd1; end
                "else":   kind = 6'd40;
                "false":  kind = 6'd41;
                "while":  kind = 6'd42;
                "return": kind = 6'd43;
                "string": begin kind = K_TYPE; code = 31'd2; end
                default:  kind = K_IDENT;
            endcase
        end
        add_token(kind, code, tok_start, word_len);
    endtask

    task automatic lex_fresh(logic [7:0] c, logic [23:0] p);
        mode = M_IDLE;
        if (is_space(c)) return;
        if (c == 8'h00) begin
            add_token(K_EOF, 0, p, 0);
        end else if (base_of(c) != 0 || c == "&" || c == "|") begin
            mode = M_OPER;
            held_op = c;
            tok_start = p;
        end else if (punct_of(c) != 0) begin
            add_token(punct_of(c), 0, p, 1);
        end else if (digit_char(c)) begin
            mode = M_NUMBER;
            number_acc = c - "0";
            digits = 1;
            tok_start = p;
        end else if (word_char(c)) begin
            mode = M_WORD;
            word_len = 1;
            kw_window = c;
            tok_start = p;
        end else if (c == 8'h22) begin
            mode = M_STRING;
            word_len = 0;
            tok_start = p + 1'b1;
        end else begin
            add_token(K_UNKNOWN, 0, p, 1);
        end
    endtask

    task automatic lex_byte(logic [7:0] c, t_row row);
        logic [23:0] p;
        logic [7:0]  dec;
        bit          again;
        p = position;
        again = 1'b0;
        new_tokens.delete();
        case (mode)
            M_OPER: begin
                mode = M_IDLE;
                if (held_op == "&" || held_op == "|") begin
                    if (c == held_op) begin
                        add_token(held_op == "&" ? K_AND : K_OR, 0, tok_start, 2);
                    end else begin
                        add_token(K_ERROR, 0, tok_start, 1);
                        again = 1'b1;
                    end
                end else if (c == "=") begin
                    add_token(base_of(held_op) + 1'b1, 0, tok_start, 2);
                end else begin
                    add_token(base_of(held_op), 0, tok_start, 1);
                    again = 1'b1;
                end
            end
            M_NUMBER: begin
                if (digit_char(c) && digits < MAX_NUMBER_DIGITS) begin
                    number_acc = number_acc * 10 + (c - "0");
                    digits++;
                end else begin
                    if (number_acc > 34'd2147483647) add_token(K_ERROR, 0, tok_start, digits);
                    else add_token(K_INT, number_acc[30:0], tok_start, digits);
                    again = 1'b1;
                end
            end
            M_WORD: begin
                if (word_char(c)) begin
                    if (word_len >= MAX_WORD_LENGTH) begin
                        add_token(K_ERROR, 0, tok_start, word_len + 17'd1);
                        mode = M_IDLE;
                    end else begin
                        word_len++;
                        kw_window = {kw_window[39:0], c};
                    end
                end else begin
                    flush_word();
                    again = 1'b1;
                end
            end
            M_STRING: begin
                if (c == 8'h22) begin
                    add_token(K_STRING, 0, tok_start, word_len);
                    mode = M_IDLE;
                end else if (c == 8'h00) begin
                    add_token(K_ERROR, 0, tok_start, word_len);
                    again = 1'b1;
                end else if (c == 8'h5C) begin
                    mode = M_ESCAPE;
                end else begin
                    add_token(K_SBYTE, c, p, 1);
                    if (word_len != 16'hFFFF) word_len++;
                end
            end
            M_ESCAPE: begin
                if (c == 8'h00) begin
                    add_token(K_ERROR, 0, tok_start, word_len);
                    again = 1'b1;
                end else begin
                    case (c)
                        "n": dec = 8'h0A;
                        "t": dec = 8'h09;
                        "r": dec = 8'h0D;
                        "0": dec = 8'h00;
                        default: dec = c;
                    endcase
                    add_token(K_SBYTE, dec, p - 1'b1, 2);
                    if (word_len != 16'hFFFF) word_len++;
                    mode = M_STRING;
                end
            end
            default: again = 1'b1;
        endcase
        if (again) lex_fresh(c, p);
        position = (c == 8'h00) ? '0 : p + 1'b1;
        if (row.typed && new_tokens.size() == 1) new_tokens[0].tok = row.tok;
        if (new_tokens.size() > 0) new_tokens[new_tokens.size() - 1].last = 1'b1;
        foreach (new_tokens[i]) token_q.push_back(new_tokens[i]);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_byte(logic [7:0] b);
        src_q.push_back('{b, 1'b0, '0});
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    function automatic logic [7:0] letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return "a" + r;
        if (r < 52) return "A" + (r - 26);
        return "_";
    endfunction

    task automatic add_fragment();
        string kw [12] = '{"if", "fn", "var", "int", "true", "bool", "else", "false",
                           "while", "return", "string", "iff"};
        string ops = "+-*/=!<>&|";
        string punct = "();:{}[],%";
        string esc = "ntr0x\\\"";
        string ws = " \t\n\r";
        logic [7:0] o;
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            push_text(kw[$urandom_range(0, 11)]);
        end else if (r < 27) begin
            n = $urandom_range(1, 8);
            if (long_words < 3 && $urandom_range(0, 40) == 0) begin
                n = $urandom_range(250, 300);
                long_words++;
            end
            for (int i = 0; i < n; i++) push_byte(letter());
        end else if (r < 42) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                push_byte((i == 0 && $urandom_range(0, 2) == 0) ? "2" : "0" + $urandom_range(0, 9));
        end else if (r < 60) begin
            o = ops[$urandom_range(0, 9)];
            push_byte(o);
            case ($urandom_range(0, 2))
                0: push_byte("=");
                1: push_byte(o);
                default: ;
            endcase
        end else if (r < 70) begin
            push_byte(punct[$urandom_range(0, 9)]);
        end else if (r < 82) begin
            push_byte(8'h22);
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    push_byte(8'h5C);
                    push_byte(esc[$urandom_range(0, 6)]);
                end else begin
                    o = $urandom_range(1, 255);
                    if (o == 8'h22 || o == 8'h5C) o = "q";
                    push_byte(o);
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1)) push_byte(8'h5C);
                push_byte(8'h00);
            end else begin
                push_byte(8'h22);
            end
        end else if (r < 90) begin
            push_byte($urandom_range(0, 255));
        end else if (r < 95) begin
            push_byte(8'h00);
        end
        if ($urandom_range(0, 2) != 0) push_byte(ws[$urandom_range(0, 3)]);
    endtask

    always @(posedge i_clk) begin : source_side
        bit took;
        t_row row;
        if (i_rst_n) begin
            if ($urandom_range(0, 299) == 0) calm <= !calm;
            took = i_valid && o_ready;
            if (took) lex_byte(i_source_byte, cur_row);
            if (!i_valid || took) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_valid <= 1'b0;
                end else if (src_q.size() > 0) begin
                    row = src_q.pop_front();
                    i_valid <= 1'b1;
                    i_source_byte <= row.b;
                    cur_row <= row;
                    in_gap <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : token_side
        t_expect e;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (token_q.size() == 0) begin
                    $display("%0t: unexpected token kind %0d", $time, o_token_kind);
                    errors++;
                end else begin
                    e = token_q.pop_front();
                    if (o_token_kind !== e.tok.kind || o_token_value !== e.tok.value ||
                        o_start_offset !== e.tok.start || o_token_length !== e.tok.length ||
                        o_run_last !== e.last) begin
                        $display("%0t: expected kind %0d value %0d start %0d len %0d last %0b",
                                 $time, e.tok.kind, e.tok.value, e.tok.start, e.tok.length,
                                 e.last);
                        $display("%0t: actual   kind %0d value %0d start %0d len %0d last %0b",
                                 $time, o_token_kind, o_token_value, o_start_offset,
                                 o_token_length, o_run_last);
                        errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_gap <= pick_gap();
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        for (int i = 0; i < N_DIR; i++) src_q.push_back(dir_table[i]);
        push_byte(8'h00);
        while (src_q.size() < 1900) add_fragment();
        push_byte(8'h00);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (src_q.size() == 0);
        @(posedge i_clk);
        while (i_valid) @(posedge i_clk);
        while (token_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && token_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule
